### sv/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge out of reset.
`define AKMR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("akmr assertion failed");

// Antecedent implies consequent on the following edge.
`define AKMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("akmr assertion failed");

`endif

### sv/akmr_pkg.sv
// Package for the analog key mouse report block: request and result types,
// register indexes and default values. No dependencies.
package akmr_pkg;

  localparam int unsigned DEPTH_W = 10;
  localparam int unsigned REG_W   = 8;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_DEADZONE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CURVE_EXP  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CURSOR_MAX = 3'd2;
  localparam logic [IDX_W-1:0] REG_SNIPE_DIV  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCROLL_MAX = 3'd4;

  localparam logic [REG_W-1:0] DEF_DEADZONE   = 8'd50;
  localparam logic [REG_W-1:0] DEF_CURVE_EXP  = 8'd2;
  localparam logic [REG_W-1:0] DEF_CURSOR_MAX = 8'd10;
  localparam logic [REG_W-1:0] DEF_SNIPE_DIV  = 8'd10;
  localparam logic [REG_W-1:0] DEF_SCROLL_MAX = 8'd5;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_up;
    logic [DEPTH_W-1:0] depth_down;
    logic [DEPTH_W-1:0] depth_left;
    logic [DEPTH_W-1:0] depth_right;
    logic [DEPTH_W-1:0] depth_wheel_up;
    logic [DEPTH_W-1:0] depth_wheel_down;
    logic [DEPTH_W-1:0] depth_wheel_left;
    logic [DEPTH_W-1:0] depth_wheel_right;
    logic [7:0]         key_active;
    logic               snipe_active;
  } req_t;

  typedef struct packed {
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel_vertical;
    logic signed [7:0] wheel_horizontal;
  } res_t;

endpackage

### sv/analog_key_mouse_report.sv
// Top level of the analog key mouse report block: sequencer, curve unit and
// serial divider. Depends on akmr_pkg and assert_macros.svh.
//
// Usage
//   Request: raise start_i with req_i; it is taken on an edge where busy_o is
//   low. busy_o stays high while the request is worked on.
//   Result: res_valid_o pulses for one cycle with res_o when some motion is
//   non-zero; a tick with no motion gives no pulse. The receiver cannot stall.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i at once; write
//   only while busy_o is low. A zero register selects its default.
// Timing
//   One shared restoring divider gives one quotient bit a cycle (DW bits, 10
//   at the default full scale). Each curve step is a multiply and then a
//   divide by the span, or the multiply alone when the product already
//   saturates. An active key past the deadzone runs its curve steps and then
//   a speed divide; other keys are skipped. Snipe adds two divides. The
//   strobe comes in the first cycle with busy_o low. One request at a time.
// Reset
//   Clears the config registers to zero (defaults) and returns the sequencer to idle.
`include "assert_macros.svh"

module analog_key_mouse_report #(
  parameter int unsigned MAX_EXPONENT = 8,
  parameter int unsigned FULL_SCALE   = 1000
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  akmr_pkg::req_t             req_i,
  output logic                       res_valid_o,
  output akmr_pkg::res_t             res_o,
  input  logic                       cfg_we_i,
  input  logic [akmr_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [akmr_pkg::REG_W-1:0] cfg_data_i
);

  localparam int unsigned FS_W  = $clog2(FULL_SCALE + 1);
  localparam int unsigned DW    = (FS_W > 8) ? FS_W : 8;     // divisor / quotient width
  localparam int unsigned PW    = FS_W + akmr_pkg::DEPTH_W;  // product width
  localparam int unsigned CW    = 2 * FS_W + 1;              // saturation bound width
  localparam int unsigned EXP_W = $clog2(MAX_EXPONENT + 1);
  localparam int unsigned CNT_W = $clog2(DW);
  localparam int unsigned AW    = 11;                        // axis sum width
  localparam logic [FS_W-1:0] FS     = FS_W'(FULL_SCALE);
  localparam logic [CW-1:0]   FS_P1  = CW'(FULL_SCALE + 1);
  localparam logic [EXP_W-1:0] EXP_MAX = EXP_W'(MAX_EXPONENT);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_KEY, ST_CURVE, ST_MUL, ST_SPEED,
    ST_DIV, ST_DIV_DONE, ST_NEXT, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    DK_CURVE, DK_SPEED, DK_SNIPE_X, DK_SNIPE_Y
  } div_kind_e;

  // configuration
  logic [akmr_pkg::REG_W-1:0] dz_q, exp_q, cmax_q, sdiv_q, smax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q   <= '0;
      exp_q  <= '0;
      cmax_q <= '0;
      sdiv_q <= '0;
      smax_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        akmr_pkg::REG_DEADZONE:   dz_q   <= cfg_data_i;
        akmr_pkg::REG_CURVE_EXP:  exp_q  <= cfg_data_i;
        akmr_pkg::REG_CURSOR_MAX: cmax_q <= cfg_data_i;
        akmr_pkg::REG_SNIPE_DIV:  sdiv_q <= cfg_data_i;
        akmr_pkg::REG_SCROLL_MAX: smax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [7:0]       dz, cmax, sdiv, smax, exp_v;
  logic [EXP_W-1:0] power;

  always_comb begin
    dz    = (dz_q   == '0) ? akmr_pkg::DEF_DEADZONE   : dz_q;
    cmax  = (cmax_q == '0) ? akmr_pkg::DEF_CURSOR_MAX : cmax_q;
    sdiv  = (sdiv_q == '0) ? akmr_pkg::DEF_SNIPE_DIV  : sdiv_q;
    smax  = (smax_q == '0) ? akmr_pkg::DEF_SCROLL_MAX : smax_q;
    exp_v = (exp_q  == '0) ? akmr_pkg::DEF_CURVE_EXP  : exp_q;
    // the default exponent saturates too
    power = (exp_v > 8'(MAX_EXPONENT)) ? EXP_MAX : EXP_W'(exp_v);
  end

  // sequencer state
  state_e                      state_q;
  div_kind_e                   kind_q;
  akmr_pkg::req_t              req_q;
  logic [2:0]                  k_q;
  logic [FS_W-1:0]             span_q;
  logic [CW-1:0]               capp_q;
  logic [akmr_pkg::DEPTH_W-1:0] eff_q;
  logic [FS_W-1:0]             acc_q;
  logic [EXP_W-1:0]            n_q;
  logic signed [AW-1:0]        x_q, y_q, v_q, h_q;
  logic                        res_valid_q;
  akmr_pkg::res_t              res_q;
  // serial divider
  logic [DW:0]                 rem_q;
  logic [DW-1:0]               sh_q;
  logic [DW-1:0]               div_q;
  logic [CNT_W-1:0]            cnt_q;

  // current key
  logic [akmr_pkg::DEPTH_W-1:0] depth;
  always_comb begin
    case (k_q)
      3'd0:    depth = req_q.depth_up;
      3'd1:    depth = req_q.depth_down;
      3'd2:    depth = req_q.depth_left;
      3'd3:    depth = req_q.depth_right;
      3'd4:    depth = req_q.depth_wheel_up;
      3'd5:    depth = req_q.depth_wheel_down;
      3'd6:    depth = req_q.depth_wheel_left;
      default: depth = req_q.depth_wheel_right;
    endcase
  end

  logic                         past_dz;
  logic [akmr_pkg::DEPTH_W-1:0] eff_d;
  logic [FS_W-1:0]              span_d;
  logic [CW-1:0]                capp_d;
  logic [PW-1:0]                p_curve, p_speed;
  logic                         p_sat;
  logic [7:0]                   top;
  logic [DW:0]                  trial;
  logic                         qbit;
  logic [7:0]                   spd;
  logic signed [AW-1:0]         xq_s, yq_s;
  logic [AW-1:0]                x_mag, y_mag;

  always_comb begin
    past_dz = {2'b00, dz} < depth;
    eff_d   = depth - {2'b00, dz};
    span_d  = ((FS_W + 4)'(dz) < (FS_W + 4)'(FULL_SCALE)) ? FS - FS_W'(dz) : '0;
    capp_d  = FS_P1 * CW'(span_d);
    p_curve = PW'(acc_q) * PW'(eff_q);
    p_sat   = {{CW{1'b0}}, p_curve} >= {{PW{1'b0}}, capp_q};
    top     = k_q[2] ? smax : cmax;
    p_speed = PW'(acc_q) * PW'(top);
    trial   = {rem_q[DW-1:0], sh_q[DW-1]};
    qbit    = trial >= {1'b0, div_q};
    spd     = (sh_q[7:0] == '0) ? 8'd1 : sh_q[7:0];
    x_mag   = x_q[AW-1] ? AW'(-x_q) : AW'(x_q);
    y_mag   = y_q[AW-1] ? AW'(-y_q) : AW'(y_q);
    xq_s    = x_q[AW-1] ? -$signed(AW'(sh_q)) : $signed(AW'(sh_q));
    yq_s    = y_q[AW-1] ? -$signed(AW'(sh_q)) : $signed(AW'(sh_q));
  end

  function automatic logic signed [7:0] clamp127(input logic signed [AW-1:0] a);
    if (a > $signed(AW'(127)))       clamp127 = 8'sd127;
    else if (a < -$signed(AW'(127))) clamp127 = -8'sd127;
    else                             clamp127 = a[7:0];
  endfunction

  akmr_pkg::res_t res_d;
  always_comb begin
    res_d.move_x           = clamp127(x_q);
    res_d.move_y           = clamp127(y_q);
    res_d.wheel_vertical   = clamp127(v_q);
    res_d.wheel_horizontal = clamp127(h_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      kind_q      <= DK_CURVE;
      k_q         <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            req_q   <= req_i;
            k_q     <= '0;
            x_q     <= '0;
            y_q     <= '0;
            v_q     <= '0;
            h_q     <= '0;
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          span_q  <= span_d;
          capp_q  <= capp_d;
          state_q <= ST_KEY;
        end
        ST_KEY: begin
          if (req_q.key_active[k_q] && past_dz) begin
            eff_q <= eff_d;
            if (span_q == '0)                                 acc_q <= '0;
            else if ({{FS_W{1'b0}}, eff_d} > {{akmr_pkg::DEPTH_W{1'b0}}, FS}) acc_q <= FS;
            else                                              acc_q <= FS_W'(eff_d);
            n_q     <= EXP_W'(1);
            state_q <= ST_CURVE;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_CURVE: begin
          if (span_q == '0 || n_q >= power) state_q <= ST_SPEED;
          else                              state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (p_sat) begin
            acc_q   <= FS;
            n_q     <= n_q + 1'b1;
            state_q <= ST_CURVE;
          end else begin
            rem_q   <= (DW + 1)'(p_curve >> DW);
            sh_q    <= p_curve[DW-1:0];
            div_q   <= DW'(span_q);
            cnt_q   <= CNT_W'(DW - 1);
            kind_q  <= DK_CURVE;
            state_q <= ST_DIV;
          end
        end
        ST_SPEED: begin
          rem_q   <= (DW + 1)'(p_speed >> DW);
          sh_q    <= p_speed[DW-1:0];
          div_q   <= DW'(FS);
          cnt_q   <= CNT_W'(DW - 1);
          kind_q  <= DK_SPEED;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= qbit ? trial - {1'b0, div_q} : trial;
          sh_q  <= {sh_q[DW-2:0], qbit};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= ST_DIV_DONE;
        end
        ST_DIV_DONE: begin
          case (kind_q)
            DK_CURVE: begin
              acc_q   <= FS_W'(sh_q);
              n_q     <= n_q + 1'b1;
              state_q <= ST_CURVE;
            end
            DK_SPEED: begin
              // up/left/wheel-down/wheel-left subtract, the rest add
              case (k_q)
                3'd0:    y_q <= y_q - $signed(AW'(spd));
                3'd1:    y_q <= y_q + $signed(AW'(spd));
                3'd2:    x_q <= x_q - $signed(AW'(spd));
                3'd3:    x_q <= x_q + $signed(AW'(spd));
                3'd4:    v_q <= v_q + $signed(AW'(spd));
                3'd5:    v_q <= v_q - $signed(AW'(spd));
                3'd6:    h_q <= h_q - $signed(AW'(spd));
                default: h_q <= h_q + $signed(AW'(spd));
              endcase
              state_q <= ST_NEXT;
            end
            DK_SNIPE_X: begin
              x_q     <= xq_s;
              rem_q   <= '0;
              sh_q    <= DW'(y_mag);
              kind_q  <= DK_SNIPE_Y;
              cnt_q   <= CNT_W'(DW - 1);
              state_q <= ST_DIV;
            end
            default: begin
              y_q     <= yq_s;
              state_q <= ST_OUT;
            end
          endcase
        end
        ST_NEXT: begin
          if (k_q == 3'd7) begin
            if (req_q.snipe_active) begin
              // magnitude divide keeps truncation toward zero
              rem_q   <= '0;
              sh_q    <= DW'(x_mag);
              div_q   <= DW'(sdiv);
              cnt_q   <= CNT_W'(DW - 1);
              kind_q  <= DK_SNIPE_X;
              state_q <= ST_DIV;
            end else begin
              state_q <= ST_OUT;
            end
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_KEY;
          end
        end
        ST_OUT: begin
          res_q       <= res_d;
          res_valid_q <= (res_d != '0);
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  `AKMR_ASSERT(a_res_nonzero, !res_valid_o || (res_o != '0))
  `AKMR_ASSERT(a_res_idle, !res_valid_o || !busy_o)
  `AKMR_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  `AKMR_ASSERT_NEXT(a_one_res, res_valid_o, !res_valid_o)

endmodule
